// ===== design/tcfr_pkg.sv =====
package tcfr_pkg;

	localparam int NUM_VC = 64;
	localparam int VC_W   = 6;

	localparam logic [3:0] BASE_OVH = 4'd5;

	typedef enum logic [2:0] {
		CFG_SCID      = 3'd0,
		CFG_VERSION   = 3'd1,
		CFG_SEG_HDR   = 3'd2,
		CFG_CRC       = 3'd3,
		CFG_MAX_FRAME = 3'd4,
		CFG_MAX_SDU   = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEN   = 3'd1,
		ST_CFG   = 3'd2,
		ST_VALID = 3'd3,
		ST_COP   = 3'd4,
		ST_QUEUE = 3'd5
	} status_t;

	localparam logic [2:0] FARM_OK    = 3'd0;
	localparam logic [2:0] FARM_ENQ   = 3'd1;
	localparam logic [2:0] FARM_PRIO  = 3'd2;
	localparam logic [2:0] FARM_ERROR = 3'd3;

	localparam logic [1:0] SEG_CONT  = 2'd0;
	localparam logic [1:0] SEG_FIRST = 2'd1;
	localparam logic [1:0] SEG_LAST  = 2'd2;
	localparam logic [1:0] SEG_UNSEG = 2'd3;

	localparam logic [1:0] ENQ_NONE = 2'd0;

	typedef struct packed {
		logic [9:0]  craft_id;
		logic [1:0]  version_number;
		logic        seg_header_present;
		logic        crc_present;
		logic [10:0] max_frame_bytes;
		logic [15:0] max_sdu_bytes;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  hdr_byte0;
		logic [7:0]  hdr_byte1;
		logic [7:0]  hdr_byte2;
		logic [7:0]  hdr_byte3;
		logic [7:0]  seg_byte;
		logic [10:0] rx_length;
		logic        vc_known;
		logic        crc_ok;
		logic [2:0]  farm_verdict;
		logic        queue_ready;
	} frm_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  enqueue;
		logic        copy_enable;
		logic [15:0] copy_offset;
		logic [10:0] copy_bytes;
	} res_word_t;

	typedef struct packed {
		logic        open;
		logic [15:0] bytes;
	} vc_ent_t;

	typedef struct packed {
		logic            en;
		logic [VC_W-1:0] vc;
		vc_ent_t         ent;
	} vc_wr_t;

endpackage

// ===== design/tcfr_cfg_regs.sv =====
module tcfr_cfg_regs
	import tcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.craft_id           <= '0;
			cfg_q.version_number     <= '0;
			cfg_q.seg_header_present <= 1'b0;
			cfg_q.crc_present        <= 1'b0;
			cfg_q.max_frame_bytes    <= 11'd1024;
			cfg_q.max_sdu_bytes      <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCID:      cfg_q.craft_id           <= cfg_data[9:0];
				CFG_VERSION:   cfg_q.version_number     <= cfg_data[1:0];
				CFG_SEG_HDR:   cfg_q.seg_header_present <= cfg_data[0];
				CFG_CRC:       cfg_q.crc_present        <= cfg_data[0];
				CFG_MAX_FRAME: cfg_q.max_frame_bytes    <= cfg_data[10:0];
				CFG_MAX_SDU:   cfg_q.max_sdu_bytes      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/tcfr_vc_state.sv =====
module tcfr_vc_state
	import tcfr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [VC_W-1:0] rd_vc,
	input  vc_wr_t          wr,
	output vc_ent_t         rd_ent
);

	vc_ent_t           mem [NUM_VC];
	logic [NUM_VC-1:0] valid_q;
	vc_ent_t           rd_q;
	vc_ent_t           byp_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.vc] <= wr.ent;
		end
		if (rd_en) begin
			rd_q  <= valid_q[rd_vc] ? mem[rd_vc] : '0;
			byp_q <= wr.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.vc] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= wr.en && (wr.vc == rd_vc);
			end
		end
	end

	// write landing on the same edge as the read
	assign rd_ent = hit_q ? byp_q : rd_q;

endmodule

// ===== design/tcfr_frame_check.sv =====
module tcfr_frame_check
	import tcfr_pkg::*;
(
	input  cfg_t      cfg,
	input  frm_word_t word,
	input  vc_ent_t   cur,
	output res_word_t res,
	output logic      wr_en,
	output vc_ent_t   wr_ent
);

	logic [9:0]  flen;
	logic [10:0] flen1;
	logic [VC_W-1:0] vc;
	logic [3:0]  ovh;
	logic [10:0] dlen;
	logic [10:0] dmax;
	logic [16:0] sum;
	logic [1:0]  ver;
	logic [9:0]  scid;
	logic        do_enq;

	assign flen  = {word.hdr_byte2[1:0], word.hdr_byte3};
	assign flen1 = {1'b0, flen} + 11'd1;
	assign vc    = word.hdr_byte2[7:2];
	assign ovh   = BASE_OVH + {3'b0, cfg.seg_header_present} + {2'b0, cfg.crc_present, 1'b0};
	assign dlen  = flen1 - {7'b0, ovh};
	assign dmax  = (cfg.max_frame_bytes > {7'b0, ovh}) ? cfg.max_frame_bytes - {7'b0, ovh}
	                                                   : 11'd0;
	assign sum   = {6'b0, dlen} + {1'b0, cur.bytes};
	assign ver   = word.hdr_byte0[7:6];
	assign scid  = {word.hdr_byte0[1:0], word.hdr_byte1};

	always_comb begin
		res    = '0;
		wr_en  = 1'b0;
		wr_ent = cur;
		do_enq = 1'b0;
		if (flen1 > word.rx_length || flen1 < {7'b0, ovh}) begin
			res.status = ST_LEN;
		end else if (!word.vc_known || int'(vc) >= NUM_VC) begin
			res.status = ST_CFG;
		end else if (ver != cfg.version_number || scid != cfg.craft_id ||
		             (cfg.crc_present && !word.crc_ok)) begin
			res.status = ST_VALID;
		end else if (word.farm_verdict == FARM_ERROR) begin
			wr_en      = 1'b1;
			wr_ent     = '0;
			res.status = ST_COP;
		end else if (word.farm_verdict == FARM_OK) begin
			res.status = ST_OK;
		end else if (word.farm_verdict != FARM_ENQ && word.farm_verdict != FARM_PRIO) begin
			res.status = ST_COP;
		end else if (cfg.seg_header_present) begin
			case (word.seg_byte[7:6])
				SEG_UNSEG: begin
					if (dlen > dmax) begin
						res.status = ST_COP;
					end else begin
						res.copy_enable = 1'b1;
						res.copy_bytes  = dlen;
						do_enq          = 1'b1;
						wr_en           = 1'b1;
						wr_ent          = '0;
					end
				end
				SEG_FIRST: begin
					wr_en = 1'b1;
					if (cur.open) begin
						wr_ent     = '0;
						res.status = ST_COP;
					end else begin
						wr_ent.bytes = {5'b0, dlen};
						if (dlen > dmax) begin
							res.status = ST_COP;
						end else begin
							res.copy_enable = 1'b1;
							res.copy_bytes  = dlen;
							wr_ent.open     = 1'b1;
						end
					end
				end
				default: begin
					wr_en = 1'b1;
					if (!cur.open) begin
						wr_ent.bytes = '0;
						res.status   = ST_COP;
					end else if (sum > {1'b0, cfg.max_sdu_bytes}) begin
						wr_ent     = '0;
						res.status = ST_COP;
					end else begin
						res.copy_enable = 1'b1;
						res.copy_offset = cur.bytes;
						res.copy_bytes  = dlen;
						if (word.seg_byte[7:6] == SEG_LAST) begin
							do_enq = 1'b1;
							wr_ent = '0;
						end else begin
							wr_ent.bytes = sum[15:0];
						end
					end
				end
			endcase
		end else begin
			wr_en  = 1'b1;
			wr_ent = '0;
			if ({5'b0, dlen} > cfg.max_sdu_bytes) begin
				res.status = ST_COP;
			end else begin
				res.copy_enable = 1'b1;
				res.copy_bytes  = dlen;
				do_enq          = 1'b1;
			end
		end
		if (do_enq) begin
			if (word.queue_ready) begin
				res.enqueue = word.farm_verdict[1:0];
			end else begin
				res.enqueue = ENQ_NONE;
				res.status  = ST_QUEUE;
			end
		end
	end

endmodule

// ===== design/tc_frame_receive_reassembler.sv =====
// channel   dir  valid      stall      word
// frm       in   frm_valid  frm_stall  frm_word (frm_word_t)
// res       out  res_valid  res_stall  res_word (res_word_t)
// cfg       in   cfg_we     -          cfg_index / cfg_data
// One frame word per cycle while res_stall is low; results are registered in res_q.
// The per-VC state read is registered at accept; the VC update is written as the
// word leaves the check stage, with a bypass for a same-VC word right behind it.
// Reset clears all VC state to closed with zero buffered bytes (valid bits).
// A stalled result holds the check stage; frm_stall rises only when both are full.
module tc_frame_receive_reassembler
	import tcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        frm_valid,
	output logic        frm_stall,
	input  frm_word_t   frm_word,
	output logic        res_valid,
	input  logic        res_stall,
	output res_word_t   res_word
);

	cfg_t      cfg;
	frm_word_t word_s1;
	logic      valid_s1;
	res_word_t res_q;
	logic      res_valid_q;
	logic      accept;
	logic      advance;
	vc_ent_t   cur;
	res_word_t res_c;
	logic      wr_en_c;
	vc_ent_t   wr_ent_c;
	vc_wr_t    wr;

	tcfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign frm_stall = valid_s1 && !advance;
	assign accept    = frm_valid && !frm_stall;

	assign wr.en  = advance && wr_en_c;
	assign wr.vc  = word_s1.hdr_byte2[7:2];
	assign wr.ent = wr_ent_c;

	tcfr_vc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_vc  (frm_word.hdr_byte2[7:2]),
		.wr     (wr),
		.rd_ent (cur)
	);

	tcfr_frame_check u_check (
		.cfg    (cfg),
		.word   (word_s1),
		.cur    (cur),
		.res    (res_c),
		.wr_en  (wr_en_c),
		.wr_ent (wr_ent_c)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= frm_word;
		end
		if (advance) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

// ===== test/tb_tc_frame_receive_reassembler.sv =====
`timescale 1ns / 1ps

module tb_tc_frame_receive_reassembler;
	import tcfr_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 320;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        frm_valid;
	logic        frm_stall;
	frm_word_t   frm_word;
	logic        res_valid;
	logic        res_stall;
	res_word_t   res_word;

	tc_frame_receive_reassembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frm_valid (frm_valid),
		.frm_stall (frm_stall),
		.frm_word  (frm_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	cfg_t        cfg_now;
	logic        vc_open [NUM_VC];
	logic [15:0] vc_fill [NUM_VC];

	frm_word_t   frames_pending [$];
	res_word_t   verdicts_due [$];

	bit          calm;
	bit          squeeze;
	bit          squeezed;
	int          hold_left;
	bit          frm_took;
	int          quiet;
	int          mismatches;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int overhead();
		return BASE_OVH + cfg_now.seg_header_present + 2 * cfg_now.crc_present;
	endfunction

	function automatic void close_channel(logic [VC_W-1:0] vc);
		vc_open[vc] = 1'b0;
		vc_fill[vc] = '0;
	endfunction

	function automatic res_word_t predict_verdict(frm_word_t w);
		res_word_t r;
		logic [VC_W-1:0] vc;
		int len, ovh, dlen, dmax;
		bit do_enq;
		r = '0;
		do_enq = 0;
		len = {w.hdr_byte2[1:0], w.hdr_byte3} + 1;
		vc = w.hdr_byte2[7:2];
		ovh = overhead();
		if (len > w.rx_length || len < ovh) begin
			r.status = ST_LEN;
			return r;
		end
		if (!w.vc_known) begin
			r.status = ST_CFG;
			return r;
		end
		dlen = len - ovh;
		dmax = (cfg_now.max_frame_bytes > ovh) ? cfg_now.max_frame_bytes - ovh : 0;
		if (w.hdr_byte0[7:6] != cfg_now.version_number ||
				{w.hdr_byte0[1:0], w.hdr_byte1} != cfg_now.craft_id ||
				(cfg_now.crc_present && !w.crc_ok)) begin
			r.status = ST_VALID;
			return r;
		end
		if (w.farm_verdict == FARM_ERROR) begin
			close_channel(vc);
			r.status = ST_COP;
			return r;
		end
		if (w.farm_verdict == FARM_OK)
			return r;
		if (w.farm_verdict != FARM_ENQ && w.farm_verdict != FARM_PRIO) begin
			r.status = ST_COP;
			return r;
		end
		if (cfg_now.seg_header_present) begin
			case (w.seg_byte[7:6])
				SEG_UNSEG: begin
					if (dlen > dmax) begin
						r.status = ST_COP;
						return r;
					end
					r.copy_offset = '0;
					do_enq = 1;
					close_channel(vc);
				end
				SEG_FIRST: begin
					if (vc_open[vc]) begin
						close_channel(vc);
						r.status = ST_COP;
						return r;
					end
					vc_fill[vc] = 16'(dlen);
					if (dlen > dmax) begin
						r.status = ST_COP;
						return r;
					end
					r.copy_offset = '0;
					vc_open[vc] = 1'b1;
				end
				default: begin
					if (!vc_open[vc]) begin
						vc_fill[vc] = '0;
						r.status = ST_COP;
						return r;
					end
					if (dlen + vc_fill[vc] > cfg_now.max_sdu_bytes) begin
						close_channel(vc);
						r.status = ST_COP;
						return r;
					end
					r.copy_offset = vc_fill[vc];
					if (w.seg_byte[7:6] == SEG_LAST) begin
						do_enq = 1;
						close_channel(vc);
					end else
						vc_fill[vc] = vc_fill[vc] + 16'(dlen);
				end
			endcase
		end else begin
			if (dlen > cfg_now.max_sdu_bytes) begin
				close_channel(vc);
				r.status = ST_COP;
				return r;
			end
			r.copy_offset = '0;
			do_enq = 1;
			close_channel(vc);
		end
		r.copy_enable = 1'b1;
		r.copy_bytes = 11'(dlen);
		if (do_enq) begin
			if (w.queue_ready)
				r.enqueue = w.farm_verdict[1:0];
			else
				r.status = ST_QUEUE;
		end
		return r;
	endfunction

	// well-formed header for the current settings
	function automatic frm_word_t build_frame(logic [VC_W-1:0] vc, logic [1:0] flag, int dlen,
			logic [2:0] farm, logic qr);
		frm_word_t w;
		int len, rxl;
		len = dlen + overhead();
		if (len > 1024)
			len = 1024;
		rxl = ($urandom_range(0, 9) == 0) ? 1024 : len + $urandom_range(0, 3);
		if (rxl > 1024)
			rxl = 1024;
		w.hdr_byte0 = {cfg_now.version_number, 4'($urandom), cfg_now.craft_id[9:8]};
		w.hdr_byte1 = cfg_now.craft_id[7:0];
		w.hdr_byte2 = {vc, 2'((len - 1) >> 8)};
		w.hdr_byte3 = 8'(len - 1);
		w.seg_byte = {flag, 6'($urandom)};
		w.rx_length = 11'(rxl);
		w.vc_known = 1'b1;
		w.crc_ok = cfg_now.crc_present ? 1'b1 : 1'($urandom);
		w.farm_verdict = farm;
		w.queue_ready = qr;
		return w;
	endfunction

	function automatic frm_word_t random_frame();
		frm_word_t w;
		int pick, dlen;
		logic [1:0] flag;
		logic [2:0] farm;
		logic [VC_W-1:0] vc;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			w = 57'({$urandom, $urandom});
			w.rx_length = 11'($urandom_range(0, 1024));
			return w;
		end
		pick = $urandom_range(0, 99);
		flag = (pick < 25) ? SEG_FIRST : (pick < 65) ? SEG_CONT : (pick < 85) ? SEG_LAST :
			SEG_UNSEG;
		dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 40);
		farm = ($urandom_range(0, 9) < 8) ? ($urandom_range(0, 1) ? FARM_ENQ : FARM_PRIO) :
			3'($urandom_range(0, 7));
		vc = ($urandom_range(0, 9) == 0) ? VC_W'($urandom) : VC_W'($urandom_range(0, 3));
		w = build_frame(vc, flag, dlen, farm, $urandom_range(0, 9) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 3)
			w.vc_known = 1'b0;
		else if (pick < 5)
			w.hdr_byte0 = w.hdr_byte0 ^ {2'($urandom_range(1, 3)), 6'd0};
		else if (pick < 7)
			w.hdr_byte1 = w.hdr_byte1 ^ 8'(1 << $urandom_range(0, 7));
		else if (pick < 9)
			w.rx_length = 11'($urandom_range(0, {w.hdr_byte2[1:0], w.hdr_byte3}));
		else if (pick < 11)
			w.crc_ok = 1'b0;
		return w;
	endfunction

	task automatic write_reg(cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SCID:      cfg_now.craft_id = 10'(val);
			CFG_VERSION:   cfg_now.version_number = 2'(val);
			CFG_SEG_HDR:   cfg_now.seg_header_present = 1'(val);
			CFG_CRC:       cfg_now.crc_present = 1'(val);
			CFG_MAX_FRAME: cfg_now.max_frame_bytes = 11'(val);
			CFG_MAX_SDU:   cfg_now.max_sdu_bytes = 16'(val);
			default: ;
		endcase
	endtask

	task automatic program_config(int scid, int ver, int seg, int crc, int frame, int sdu);
		write_reg(CFG_SCID, scid);
		write_reg(CFG_VERSION, ver);
		write_reg(CFG_SEG_HDR, seg);
		write_reg(CFG_CRC, crc);
		write_reg(CFG_MAX_FRAME, frame);
		write_reg(CFG_MAX_SDU, sdu);
	endtask

	task automatic drain();
		while (frames_pending.size() != 0 || frm_valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic check_field(string tag, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t %s expected %0d actual %0d", $time, tag, want, got);
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n)
			frm_valid <= 1'b0;
		else if (!frm_valid || frm_took) begin
			if (frames_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
				frm_valid <= 1'b1;
				frm_word <= frames_pending.pop_front();
			end else
				frm_valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (squeeze && !squeezed) begin
			squeezed = 1;
			hold_left = SQUEEZE_CYCLES;
			res_stall <= 1'b1;
		end else
			res_stall <= !calm && $urandom_range(0, 99) < 33;
	end

	always @(posedge clk) begin : monitor
		res_word_t want;
		bit res_took;
		frm_took = arst_n && frm_valid && !frm_stall;
		res_took = arst_n && res_valid && !res_stall;
		if (frm_took)
			verdicts_due.push_back(predict_verdict(frm_word));
		if (res_took) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result word expected none actual %p", $time, res_word);
			end else begin
				want = verdicts_due.pop_front();
				check_field("status", want.status, res_word.status);
				check_field("enqueue", want.enqueue, res_word.enqueue);
				check_field("copy_enable", want.copy_enable, res_word.copy_enable);
				check_field("copy_offset", want.copy_offset, res_word.copy_offset);
				check_field("copy_bytes", want.copy_bytes, res_word.copy_bytes);
			end
		end
		if (frm_took || res_took)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		frm_word_t w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frm_valid = 1'b0;
		frm_word = '0;
		res_stall = 1'b0;
		calm = 0;
		squeeze = 0;
		squeezed = 0;
		hold_left = 0;
		quiet = 0;
		mismatches = 0;
		cfg_now = '{craft_id: '0, version_number: '0, seg_header_present: 1'b0,
			crc_present: 1'b0, max_frame_bytes: 11'd1024, max_sdu_bytes: 16'd1024};
		for (int i = 0; i < NUM_VC; i++) begin
			vc_open[i] = 1'b0;
			vc_fill[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			calm = (phase == 1);
			case (phase)
				0: program_config(10'h2a5, 2, 1, 1, 1024, 300);
				1: program_config(1023, 3, 1, 0, 64, 65535);
				2: program_config(0, 0, 0, 0, 6, 1);
				3: program_config($urandom_range(0, 1023), 1, 0, 1, 1024, 1024);
				4: program_config($urandom_range(0, 1023), $urandom_range(0, 3), 1,
					$urandom_range(0, 1), 6, 2000);
				default: program_config($urandom_range(0, 1023), $urandom_range(0, 3), 1, 1,
					$urandom_range(6, 1024), $urandom_range(1, 4000));
			endcase
			if (phase == 0) begin
				w = build_frame(1, SEG_UNSEG, 4, FARM_ENQ, 1);
				w.rx_length = 11'd11;
				frames_pending.push_back(w);
				w = build_frame(1, SEG_UNSEG, 0, FARM_ENQ, 1);
				w.hdr_byte3 = 8'd3;
				frames_pending.push_back(w);
				w = build_frame(2, SEG_UNSEG, 4, FARM_ENQ, 1);
				w.vc_known = 1'b0;
				frames_pending.push_back(w);
				w = build_frame(2, SEG_UNSEG, 4, FARM_ENQ, 1);
				w.hdr_byte0[7:6] = 2'd1;
				frames_pending.push_back(w);
				w = build_frame(2, SEG_UNSEG, 4, FARM_ENQ, 1);
				w.hdr_byte1 = w.hdr_byte1 ^ 8'h01;
				frames_pending.push_back(w);
				w = build_frame(2, SEG_UNSEG, 4, FARM_ENQ, 1);
				w.crc_ok = 1'b0;
				frames_pending.push_back(w);
				// full first / continuation / last sequence
				frames_pending.push_back(build_frame(5, SEG_FIRST, 10, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(5, SEG_CONT, 20, FARM_PRIO, 1));
				frames_pending.push_back(build_frame(5, SEG_LAST, 5, FARM_PRIO, 1));
				frames_pending.push_back(build_frame(5, SEG_CONT, 3, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(6, SEG_FIRST, 1, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(6, SEG_FIRST, 2, FARM_ENQ, 1));
				// sdu overflow on continuation
				frames_pending.push_back(build_frame(7, SEG_FIRST, 280, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(7, SEG_CONT, 30, FARM_ENQ, 1));
				w = build_frame(63, SEG_UNSEG, 1016, FARM_ENQ, 0);
				w.rx_length = 11'd1024;
				frames_pending.push_back(w);
				frames_pending.push_back(build_frame(8, SEG_FIRST, 4, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(8, SEG_CONT, 4, FARM_ERROR, 1));
				frames_pending.push_back(build_frame(8, SEG_LAST, 4, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(9, SEG_UNSEG, 2, FARM_OK, 1));
				frames_pending.push_back(build_frame(9, SEG_UNSEG, 2, 3'd7, 1));
				frames_pending.push_back(build_frame(9, SEG_UNSEG, 2, 3'd4, 1));
				w = build_frame(0, SEG_UNSEG, 0, FARM_PRIO, 1);
				w.hdr_byte0[5:2] = 4'hf;
				w.seg_byte[5:0] = 6'h3f;
				frames_pending.push_back(w);
				frames_pending.push_back(build_frame(10, SEG_FIRST, 7, FARM_ENQ, 1));
				frames_pending.push_back(build_frame(10, SEG_LAST, 0, FARM_ENQ, 0));
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				frames_pending.push_back(random_frame());
			if (phase == 3)
				squeeze = 1;
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== tc_frame_receive_reassembler.f =====
design/tcfr_pkg.sv
design/tcfr_cfg_regs.sv
design/tcfr_vc_state.sv
design/tcfr_frame_check.sv
design/tc_frame_receive_reassembler.sv
test/tb_tc_frame_receive_reassembler.sv
